// ===== sv/lwvd_pkg.sv =====
// ----------------------------------------------------------------------------
// Level window valve drive package
// Shared widths, constants and the divider request type.
// ----------------------------------------------------------------------------
package lwvd_pkg;

    localparam int DIV_W   = 24;
    localparam int DEN_W   = 16;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int ANG_W   = 8;
    localparam int PULSE_W = 12;

    localparam logic [IDX_W-1:0] REG_WINDOW_LOW     = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_HIGH    = 3'd1;
    localparam logic [IDX_W-1:0] REG_LED1_MODE      = 3'd2;
    localparam logic [IDX_W-1:0] REG_LED2_MODE      = 3'd3;
    localparam logic [IDX_W-1:0] REG_MANUAL_ALLOWED = 3'd4;
    localparam logic [IDX_W-1:0] REG_VALVE_LOW      = 3'd5;
    localparam logic [IDX_W-1:0] REG_VALVE_HIGH     = 3'd6;

    localparam logic [DEN_W-1:0]   POT_SPAN     = 16'd1023;
    localparam logic [12:0]        PULSE_MUL    = 13'd25;
    localparam logic [DEN_W-1:0]   PULSE_DIV    = 16'd3;
    localparam logic [PULSE_W-1:0] PULSE_BASE   = 12'd750;
    localparam logic [ANG_W-1:0]   VALVE_HI_RST = 8'd180;
    localparam logic [ANG_W-1:0]   THIRD_MUL    = 8'd171;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

endpackage

// ===== sv/level_window_valve_drive.sv =====
// ----------------------------------------------------------------------------
// Level window valve drive
// Window check, LED drive, valve angle mapping and servo pulse per sample.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time. For a sample inside the window whose
// angle is mapped from distance or potentiometer, the result beat waits on
// the shared 24-step divider that computes the angle; any other sample goes
// straight from the idle state to the pulse state. The result is offered in
// the output state, and the block is ready for the next sample in the cycle
// after its result beat is taken.
module level_window_valve_drive import lwvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_distance,
    input  logic [31:0]        i_now_ms,
    input  logic               i_button_changed,
    input  logic [9:0]         i_pot_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_level_ok,
    output logic               o_led1_on,
    output logic               o_led2_on,
    output logic [ANG_W-1:0]   o_valve_angle,
    output logic [PULSE_W-1:0] o_servo_pulse_us
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MAP    = 3'd1;
    localparam logic [2:0] S_PULSE  = 3'd2;
    localparam logic [2:0] S_OUT    = 3'd3;

    logic [2:0]         r_state;
    logic [15:0]        r_win_lo;
    logic [15:0]        r_win_hi;
    logic               r_led1_mode;
    logic [15:0]        r_led2_mode;
    logic               r_man_allowed;
    logic [ANG_W-1:0]   r_valve_lo;
    logic [ANG_W-1:0]   r_valve_hi;
    logic               r_man_active;
    logic               r_blink_phase;
    logic [31:0]        r_last_toggle;
    logic               r_led1;
    logic               r_led2;
    logic [ANG_W-1:0]   r_angle;
    logic               r_ok;
    logic               r_neg;
    logic [PULSE_W-1:0] r_pulse;

    logic               accept;
    logic               ok;
    logic               use_man;
    logic               need_div;
    logic [8:0]         dy;
    logic [ANG_W-1:0]   dy_mag;
    logic [15:0]        x;
    logic [DEN_W-1:0]   span;
    logic [31:0]        elapsed;
    logic [ANG_W-1:0]   mapped;
    logic [ANG_W-1:0]   q_lo;
    logic [ANG_W-1:0]   n_angle;
    logic [15:0]        third_prod;
    logic [PULSE_W-1:0] pulse;
    t_div_req           div_req;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign ok       = (i_distance > r_win_lo) && (i_distance <= r_win_hi);
    assign use_man  = r_man_allowed && (r_man_active ^ i_button_changed);
    assign need_div = ok && (use_man || (r_valve_lo != r_valve_hi));
    assign dy       = {1'b0, r_valve_lo} - {1'b0, r_valve_hi};
    assign dy_mag   = dy[8] ? ANG_W'(-dy) : dy[ANG_W-1:0];
    assign x        = use_man ? {6'b0, i_pot_value} : (i_distance - r_win_lo);
    assign span     = use_man ? POT_SPAN : (r_win_hi - r_win_lo);
    assign elapsed  = i_now_ms - r_last_toggle;
    assign q_lo     = div_quot[ANG_W-1:0];
    assign mapped   = r_neg ? (r_valve_hi - q_lo) : (r_valve_hi + q_lo);

    // The pulse is the base plus eight times the angle plus a third of it, the
    // third by a reciprocal multiply that is exact over the whole angle range.
    assign third_prod = {8'b0, r_angle} * {8'b0, THIRD_MUL};
    assign pulse      = PULSE_BASE + {1'b0, r_angle, 3'b0} + {5'b0, third_prod[15:9]};

    always_comb begin
        n_angle = r_angle;
        if (ok && !need_div) begin
            n_angle = r_valve_lo;
        end
    end

    always_comb begin
        div_req = '0;
        if (accept && need_div) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(x) * DIV_W'(dy_mag);
            div_req.divisor  = span;
        end
    end

    lwvd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo      <= '0;
            r_win_hi      <= '0;
            r_led1_mode   <= 1'b0;
            r_led2_mode   <= '0;
            r_man_allowed <= 1'b0;
            r_valve_lo    <= '0;
            r_valve_hi    <= VALVE_HI_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_LOW:     r_win_lo      <= i_cfg_data;
                REG_WINDOW_HIGH:    r_win_hi      <= i_cfg_data;
                REG_LED1_MODE:      r_led1_mode   <= i_cfg_data[0];
                REG_LED2_MODE:      r_led2_mode   <= i_cfg_data;
                REG_MANUAL_ALLOWED: r_man_allowed <= i_cfg_data[0];
                REG_VALVE_LOW:      r_valve_lo    <= i_cfg_data[ANG_W-1:0];
                REG_VALVE_HIGH:     r_valve_hi    <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_man_active  <= 1'b0;
            r_blink_phase <= 1'b1;
            r_last_toggle <= '0;
            r_led1        <= 1'b0;
            r_led2        <= 1'b0;
            r_angle       <= '0;
            r_ok          <= 1'b0;
            r_neg         <= 1'b0;
            r_pulse       <= PULSE_BASE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ok    <= ok;
                        r_neg   <= dy[8];
                        r_angle <= n_angle;
                        r_state <= need_div ? S_MAP : S_PULSE;
                        if (ok) begin
                            r_led1 <= r_led1_mode;
                            if (r_led2_mode > 16'd1) begin
                                if (r_blink_phase) begin
                                    r_led2        <= ~r_led2;
                                    r_blink_phase <= 1'b0;
                                end else if (elapsed >= {16'b0, r_led2_mode}) begin
                                    r_last_toggle <= i_now_ms;
                                    r_blink_phase <= 1'b1;
                                end
                            end else begin
                                r_led2 <= r_led2_mode[0];
                            end
                            if (r_man_allowed && i_button_changed) begin
                                r_man_active <= ~r_man_active;
                            end
                        end
                    end
                end
                S_MAP: begin
                    if (div_done) begin
                        r_angle <= mapped;
                        r_state <= S_PULSE;
                    end
                end
                S_PULSE: begin
                    r_pulse <= pulse;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_level_ok       = r_ok;
    assign o_led1_on        = r_led1;
    assign o_led2_on        = r_led2;
    assign o_valve_angle    = r_angle;
    assign o_servo_pulse_us = r_pulse;

endmodule

// ===== sv/lwvd_div.sv =====
// ----------------------------------------------------------------------------
// Level window valve drive divider
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lwvd_div import lwvd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DIV_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    assign trial = {r_rem, r_num[DIV_W-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_num <= {r_num[DIV_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// ===== bench/valve_drive_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve drive checker
// Watches the register port and both channels of the level window valve
// drive. It keeps its own copy of the registers and drive state, works out
// the result for every accepted sample beat, queues it, and compares each
// result beat with the oldest queued result field by field.
// ----------------------------------------------------------------------------
module valve_drive_checker import lwvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [15:0]        i_distance,
    input  logic [31:0]        i_now_ms,
    input  logic               i_button_changed,
    input  logic [9:0]         i_pot_value,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_level_ok,
    input  logic               i_led1_on,
    input  logic               i_led2_on,
    input  logic [ANG_W-1:0]   i_valve_angle,
    input  logic [PULSE_W-1:0] i_servo_pulse_us,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_in_window,
    output int                 o_manual_count
);

    typedef struct {
        logic               level_ok;
        logic               led1_on;
        logic               led2_on;
        logic [ANG_W-1:0]   valve_angle;
        logic [PULSE_W-1:0] servo_pulse_us;
    } t_drive_result;

    logic [15:0]      win_low;
    logic [15:0]      win_high;
    logic             led1_mode;
    logic [15:0]      led2_mode;
    logic             manual_allowed;
    logic [ANG_W-1:0] valve_low;
    logic [ANG_W-1:0] valve_high;

    logic             manual_active;
    logic             blink_phase;
    logic [31:0]      last_toggle;
    logic             led1_level;
    logic             led2_level;
    logic [ANG_W-1:0] angle;

    t_drive_result drive_results_due[$];

    function automatic logic [ANG_W-1:0] map_linear(input int x, input int x0, input int span,
                                                    input int y0, input int y1);
        int prod;
        prod = (x - x0) * (y1 - y0);
        return ANG_W'(prod / span + y0);
    endfunction

    function automatic t_drive_result next_drive(input logic [15:0] sample_dist,
                                                 input logic [31:0] now,
                                                 input logic btn,
                                                 input logic [9:0] pot);
        t_drive_result r;
        logic in_win;
        in_win = (sample_dist > win_low) && (sample_dist <= win_high);
        if (in_win) begin
            o_in_window++;
            led1_level = led1_mode;
            if (led2_mode > 16'd1) begin
                if (blink_phase) begin
                    led2_level = ~led2_level;
                    blink_phase = 1'b0;
                end else if (32'(now - last_toggle) >= 32'(led2_mode)) begin
                    last_toggle = now;
                    blink_phase = 1'b1;
                end
            end else begin
                led2_level = (led2_mode == 16'd1);
            end
            if (valve_low != valve_high) begin
                angle = map_linear(int'(sample_dist), int'(win_low),
                                   int'(win_high) - int'(win_low),
                                   int'(valve_high), int'(valve_low));
            end else begin
                angle = valve_low;
            end
            if (manual_allowed && btn) begin
                manual_active = ~manual_active;
            end
            if (manual_allowed && manual_active) begin
                angle = map_linear(int'(pot), 0, int'(POT_SPAN), int'(valve_high),
                                   int'(valve_low));
                o_manual_count++;
            end
        end
        r.level_ok       = in_win;
        r.led1_on        = led1_level;
        r.led2_on        = led2_level;
        r.valve_angle    = angle;
        r.servo_pulse_us = PULSE_W'(int'(PULSE_BASE) +
                                    (int'(angle) * int'(PULSE_MUL)) / int'(PULSE_DIV));
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_drive_result want;
        if (!i_rst_n) begin
            win_low        = '0;
            win_high       = '0;
            led1_mode      = 1'b0;
            led2_mode      = '0;
            manual_allowed = 1'b0;
            valve_low      = '0;
            valve_high     = VALVE_HI_RST;
            manual_active  = 1'b0;
            blink_phase    = 1'b1;
            last_toggle    = '0;
            led1_level     = 1'b0;
            led2_level     = 1'b0;
            angle          = '0;
            drive_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WINDOW_LOW:     win_low        = i_cfg_data;
                    REG_WINDOW_HIGH:    win_high       = i_cfg_data;
                    REG_LED1_MODE:      led1_mode      = i_cfg_data[0];
                    REG_LED2_MODE:      led2_mode      = i_cfg_data;
                    REG_MANUAL_ALLOWED: manual_allowed = i_cfg_data[0];
                    REG_VALVE_LOW:      valve_low      = i_cfg_data[ANG_W-1:0];
                    REG_VALVE_HIGH:     valve_high     = i_cfg_data[ANG_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (drive_results_due.size() == 0) begin
                    $display("%0t ns: result beat with no sample pending, got ok=%0d angle=%0d",
                             $time, i_level_ok, i_valve_angle);
                    o_fail_count++;
                end else begin
                    want = drive_results_due.pop_front();
                    check_field("level_ok", want.level_ok, i_level_ok);
                    check_field("led1_on", want.led1_on, i_led1_on);
                    check_field("led2_on", want.led2_on, i_led2_on);
                    check_field("valve_angle", want.valve_angle, i_valve_angle);
                    check_field("servo_pulse_us", want.servo_pulse_us, i_servo_pulse_us);
                end
            end
            if (i_in_valid && i_in_ready) begin
                drive_results_due.push_back(next_drive(i_distance, i_now_ms,
                                                       i_button_changed, i_pot_value));
            end
        end
        o_pending = drive_results_due.size();
    end

endmodule

// ===== bench/level_window_valve_drive_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level window valve drive testbench
// Drives directed and random distance samples through several register
// settings and idling patterns, including two long output hold-offs, while a
// separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module level_window_valve_drive_test;
    import lwvd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 118;
    localparam int DRAIN_CYCLES   = 60;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_we         = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx        = '0;
    logic [CFG_W-1:0]   i_cfg_data       = '0;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic [15:0]        i_distance       = '0;
    logic [31:0]        i_now_ms         = '0;
    logic               i_button_changed = 1'b0;
    logic [9:0]         i_pot_value      = '0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic               o_level_ok;
    logic               o_led1_on;
    logic               o_led2_on;
    logic [ANG_W-1:0]   o_valve_angle;
    logic [PULSE_W-1:0] o_servo_pulse_us;

    int fail_count;
    int pending;
    int in_window;
    int manual_count;

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_seq  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int          cur_low;
    int          cur_high;
    logic [31:0] clock_ms = '0;
    int          samples_sent = 0;
    int          settings_used = 0;

    level_window_valve_drive u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_distance       (i_distance),
        .i_now_ms         (i_now_ms),
        .i_button_changed (i_button_changed),
        .i_pot_value      (i_pot_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_level_ok       (o_level_ok),
        .o_led1_on        (o_led1_on),
        .o_led2_on        (o_led2_on),
        .o_valve_angle    (o_valve_angle),
        .o_servo_pulse_us (o_servo_pulse_us)
    );

    valve_drive_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_distance       (i_distance),
        .i_now_ms         (i_now_ms),
        .i_button_changed (i_button_changed),
        .i_pot_value      (i_pot_value),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_level_ok       (o_level_ok),
        .i_led1_on        (o_led1_on),
        .i_led2_on        (o_led2_on),
        .i_valve_angle    (o_valve_angle),
        .i_servo_pulse_us (o_servo_pulse_us),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_in_window      (in_window),
        .o_manual_count   (manual_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end

    // A long hold-off is started whenever the stimulus bumps hold_seq.
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready = 1'b0;
        end else begin
            i_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_sample(input logic [15:0] sample_dist, input logic [31:0] now,
                               input logic btn, input logic [9:0] pot);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        i_valid          = 1'b1;
        i_distance       = sample_dist;
        i_now_ms         = now;
        i_button_changed = btn;
        i_pot_value      = pot;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_valid = 1'b0;
        samples_sent++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] low, input logic [15:0] high,
                                 input logic [15:0] led1, input logic [15:0] led2,
                                 input logic [15:0] manual, input logic [15:0] vlow,
                                 input logic [15:0] vhigh);
        while (pending != 0) @(negedge i_clk);
        write_reg(REG_WINDOW_LOW, low);
        write_reg(REG_WINDOW_HIGH, high);
        write_reg(REG_LED1_MODE, led1);
        write_reg(REG_LED2_MODE, led2);
        write_reg(REG_MANUAL_ALLOWED, manual);
        write_reg(REG_VALVE_LOW, vlow);
        write_reg(REG_VALVE_HIGH, vhigh);
        cur_low  = int'(low);
        cur_high = int'(high);
        settings_used++;
    endtask

    task automatic send_random();
        logic [15:0] sample_dist;
        logic [9:0]  pot;
        int          pick;
        pick = $urandom_range(99);
        if (cur_high > cur_low && pick < 65) begin
            sample_dist = 16'(cur_low + 1 + $urandom_range(cur_high - cur_low - 1));
        end else if (pick < 80) begin
            case ($urandom_range(3))
                0:       sample_dist = 16'(cur_low);
                1:       sample_dist = 16'(cur_low + 1);
                2:       sample_dist = 16'(cur_high);
                default: sample_dist = 16'(cur_high + 1);
            endcase
        end else begin
            sample_dist = 16'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            clock_ms = clock_ms + $urandom_range(20);
        end else if (pick < 95) begin
            clock_ms = clock_ms + $urandom_range(70000);
        end else begin
            clock_ms = $urandom;
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            pot = '0;
        end else if (pick == 1) begin
            pot = '1;
        end else begin
            pot = 10'($urandom);
        end
        send_sample(sample_dist, clock_ms, ($urandom_range(99) < 25), pot);
    endtask

    initial begin
        int          low;
        int          high;
        logic [15:0] led2;
        logic [7:0]  vlow;
        logic [7:0]  vhigh;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers give an empty window, so everything holds.
        cur_low  = 0;
        cur_high = 0;
        send_sample(16'd0, 32'd0, 1'b0, 10'd0);

        apply_setting(16'd100, 16'd1100, 16'd1, 16'd0, 16'd1, 16'd0, 16'd180);
        send_sample(16'd100, 32'd1, 1'b0, 10'd0);
        send_sample(16'd101, 32'd2, 1'b0, 10'd0);
        send_sample(16'd1100, 32'd3, 1'b0, 10'd0);
        send_sample(16'd1101, 32'd4, 1'b0, 10'd0);
        send_sample(16'hFFFF, 32'hFFFF_FFFF, 1'b1, 10'h3FF);
        send_sample(16'd600, 32'd10, 1'b1, 10'd0);
        send_sample(16'd600, 32'd11, 1'b0, 10'h3FF);
        send_sample(16'd600, 32'd12, 1'b0, 10'd512);
        send_sample(16'd600, 32'd13, 1'b1, 10'd512);

        // Manual not allowed and equal valve ends.
        apply_setting(16'd100, 16'd1100, 16'd0, 16'd1, 16'd0, 16'd90, 16'd90);
        send_sample(16'd600, 32'd20, 1'b1, 10'd700);
        send_sample(16'd1100, 32'd21, 1'b1, 10'd3);

        // Full window, blinking across the time wrap, valve ends above 180.
        apply_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'd10, 16'd1, 16'd255, 16'd200);
        send_sample(16'd1, 32'hFFFF_FFF0, 1'b0, 10'd0);
        send_sample(16'hFFFF, 32'hFFFF_FFF5, 1'b1, 10'h3FF);
        send_sample(16'd32768, 32'hFFFF_FFF8, 1'b0, 10'd1);
        send_sample(16'd40000, 32'h0000_0002, 1'b0, 10'd1000);
        send_sample(16'd2, 32'h0000_0003, 1'b1, 10'd0);
        send_sample(16'd3, 32'h0000_0004, 1'b0, 10'd0);

        // Empty window with equal bounds.
        apply_setting(16'd500, 16'd500, 16'd1, 16'd1, 16'd1, 16'd10, 16'd20);
        send_sample(16'd500, 32'd50, 1'b1, 10'd5);
        send_sample(16'd501, 32'd51, 1'b1, 10'd5);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setting(16'd1000, 16'd5000, 16'd1, 16'd0, 16'd0, 16'd0, 16'd180);
                1: apply_setting(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1, 16'd180, 16'd0);
                2: apply_setting(16'd100, 16'd400, 16'd1, 16'd25, 16'd1, 16'd30, 16'd150);
                default: begin
                    low = $urandom_range(40000);
                    if ($urandom_range(9) == 0) begin
                        high = $urandom_range(low);
                    end else begin
                        high = low + $urandom_range(65535 - low - 1) + 1;
                    end
                    case ($urandom_range(3))
                        0:       led2 = 16'd0;
                        1:       led2 = 16'd1;
                        2:       led2 = 16'($urandom_range(40, 2));
                        default: led2 = 16'($urandom_range(65535, 2));
                    endcase
                    if ($urandom_range(4) == 0) begin
                        vlow = 8'($urandom);
                    end else begin
                        vlow = 8'($urandom_range(180));
                    end
                    vhigh = ($urandom_range(5) == 0) ? vlow : 8'($urandom_range(180));
                    apply_setting(16'(low), 16'(high), 16'($urandom), led2, 16'($urandom),
                                  {8'($urandom), vlow}, {8'($urandom), vhigh});
                end
            endcase
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 74;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 74;
                end
                default: begin
                    idle_pct  = 23;
                    stall_pct = 23;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ((ph == 0 && k == 20) || (ph == 5 && k == 60)) begin
                    hold_seq++;
                end
                send_random();
            end
        end

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d samples over %0d register settings: %0d inside the window, %0d on the pot.",
                 samples_sent, settings_used, in_window, manual_count);
        $display("Idling patterns: none, sender, receiver and both, plus two long output hold-offs.");
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
